// File: design/lrd_pkg.sv
package lrd_pkg;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERRUN   = 2'd1;
  localparam logic [1:0] STAT_ZERO_FILL = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TOK_LO,
    PH_TOK_HI,
    PH_FILL,
    PH_LIT,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_COPY,
    ST_RUN,
    ST_ERROR,
    ST_END
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    logic       load_in;
    logic       hdr_load;
    logic       tok_lo_load;
    logic       fill_load;
    logic       lit_load;
    logic       lit_dec;
    logic       match_load;
    logic       fill_run_load;
    logic       lit_run_load;
    logic       mem_read;
    logic       emit_data;
    logic       src_mem;
    logic       emit_err;
    logic [1:0] err_status;
  } lrd_cmd_t;

  typedef struct packed {
    logic last_in;
    logic hdr_last;
    logic is_fill;
    logic off_zero;
    logic len_zero;
    logic lit_zero;
    logic overrun;
    logic lit_one;
    logic run_one;
    logic bw_zero;
    logic size_nonzero;
    logic can_load;
  } lrd_stat_t;

endpackage

// File: design/lrd_datapath.sv
module lrd_datapath import lrd_pkg::*; #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  in_word_t  in_word,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word,
  input  lrd_cmd_t  cmd,
  output lrd_stat_t stat
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  logic [7:0]    hist [HISTORY_DEPTH];

  logic [7:0]    held_byte;
  logic          held_last;
  logic [31:0]   declared_size;
  logic [1:0]    header_count;
  logic [7:0]    token_low;
  logic [5:0]    fill_count;
  logic [4:0]    literals_left;
  logic [5:0]    run_count;
  logic [6:0]    reach;
  logic [AW-1:0] wr_ptr;
  logic          wrapped;
  logic [31:0]   bytes_written;
  logic [7:0]    rd_data;
  logic          rd_ok;

  logic [5:0]    tok_off;
  logic [4:0]    tok_len;
  logic [4:0]    tok_lit;
  logic [5:0]    need;
  logic [32:0]   total;
  logic [AW:0]   wr_wide;
  logic [AW:0]   dist_wide;
  logic [AW:0]   src_wide;
  logic [AW-1:0] src;
  logic [7:0]    data_sel;

  assign tok_off   = held_byte[7:2];
  assign tok_len   = {held_byte[1:0], token_low[7:5]};
  assign tok_lit   = token_low[4:0];
  assign need      = stat.is_fill ? tok_off : (6'(tok_len) + 6'(tok_lit));
  assign total     = {1'b0, bytes_written} + 33'(need);

  assign wr_wide   = {1'b0, wr_ptr};
  assign dist_wide = (AW+1)'(reach);
  assign src_wide  = (wr_wide >= dist_wide) ? wr_wide - dist_wide
                                            : wr_wide + DEPTH_W - dist_wide;
  assign src       = src_wide[AW-1:0];

  // entries never written read as zero
  assign data_sel  = cmd.src_mem ? (rd_ok ? rd_data : 8'd0) : held_byte;

  always_comb begin
    stat.last_in      = held_last;
    stat.hdr_last     = (header_count == 2'd3);
    stat.is_fill      = (tok_len == 5'd0) && (tok_lit == 5'd0);
    stat.off_zero     = (tok_off == 6'd0);
    stat.len_zero     = (tok_len == 5'd0);
    stat.lit_zero     = (tok_lit == 5'd0);
    stat.overrun      = total > {1'b0, declared_size};
    stat.lit_one      = (literals_left == 5'd1);
    stat.run_one      = (run_count == 6'd1);
    stat.bw_zero      = (bytes_written == 32'd0);
    stat.size_nonzero = (declared_size != 32'd0);
    stat.can_load     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_data) begin
      hist[wr_ptr] <= data_sel;
    end
    if (cmd.mem_read) begin
      rd_data <= hist[src];
      rd_ok   <= wrapped || (wr_wide >= dist_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      held_byte <= in_word.in_byte;
      held_last <= in_word.last_byte;
    end
    if (cmd.match_load) begin
      run_count <= 6'(tok_len);
      reach     <= 7'(tok_off) + 7'(tok_len);
    end else if (cmd.fill_run_load) begin
      run_count <= fill_count;
    end else if (cmd.lit_run_load) begin
      run_count <= 6'd1;
    end else if (cmd.emit_data) begin
      run_count <= run_count - 6'd1;
    end
    if (cmd.emit_data) begin
      out_word <= '{out_byte: data_sel, last_of_run: stat.run_one, status: STAT_OK};
    end else if (cmd.emit_err) begin
      out_word <= '{out_byte: 8'd0, last_of_run: 1'b1, status: cmd.err_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      declared_size <= '0;
      header_count  <= '0;
      token_low     <= '0;
      fill_count    <= '0;
      literals_left <= '0;
      wr_ptr        <= '0;
      wrapped       <= 1'b0;
      bytes_written <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.hdr_load) begin
        declared_size[8*header_count +: 8] <= held_byte;
        header_count <= header_count + 2'd1;
      end
      if (cmd.tok_lo_load) begin
        token_low <= held_byte;
      end
      if (cmd.fill_load) begin
        fill_count <= tok_off;
      end else if (cmd.fill_run_load) begin
        fill_count <= '0;
      end
      if (cmd.lit_load) begin
        literals_left <= tok_lit;
      end else if (cmd.lit_dec) begin
        literals_left <= literals_left - 5'd1;
      end
      if (cmd.emit_data) begin
        wr_ptr        <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
        wrapped       <= wrapped || (wr_ptr == LAST_IDX);
        bytes_written <= bytes_written + 32'd1;
      end
      if (cmd.emit_data || cmd.emit_err) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/lrd_ctrl.sv
module lrd_ctrl import lrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  lrd_stat_t stat,
  output lrd_cmd_t  cmd
);

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] err_code, err_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_HEADER;
      err_code <= STAT_OK;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      err_code <= err_code_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    err_code_next = err_code;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = (phase != PH_DONE);
        if (in_valid && in_ready) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_END;
        case (phase)
          PH_HEADER: begin
            cmd.hdr_load = 1'b1;
            if (stat.hdr_last) begin
              phase_next = PH_TOK_LO;
            end
          end
          PH_TOK_LO: begin
            cmd.tok_lo_load = 1'b1;
            phase_next      = PH_TOK_HI;
          end
          PH_TOK_HI: begin
            if (stat.is_fill && stat.off_zero) begin
              err_code_next = STAT_ZERO_FILL;
              state_next    = ST_ERROR;
            end else if (stat.overrun) begin
              err_code_next = STAT_OVERRUN;
              state_next    = ST_ERROR;
            end else if (stat.is_fill) begin
              cmd.fill_load = 1'b1;
              phase_next    = PH_FILL;
            end else begin
              cmd.lit_load = 1'b1;
              phase_next   = stat.lit_zero ? PH_TOK_LO : PH_LIT;
              if (!stat.len_zero) begin
                cmd.match_load = 1'b1;
                state_next     = ST_READ;
              end
            end
          end
          PH_FILL: begin
            cmd.fill_run_load = 1'b1;
            phase_next        = PH_TOK_LO;
            state_next        = ST_RUN;
          end
          PH_LIT: begin
            cmd.lit_run_load = 1'b1;
            cmd.lit_dec      = 1'b1;
            if (stat.lit_one) begin
              phase_next = PH_TOK_LO;
            end
            state_next = ST_RUN;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = ST_COPY;
      end
      ST_COPY: begin
        if (stat.can_load) begin
          cmd.emit_data = 1'b1;
          cmd.src_mem   = 1'b1;
          state_next    = stat.run_one ? ST_END : ST_READ;
        end
      end
      ST_RUN: begin
        if (stat.can_load) begin
          cmd.emit_data = 1'b1;
          if (stat.run_one) begin
            state_next = ST_END;
          end
        end
      end
      ST_ERROR: begin
        if (stat.can_load) begin
          cmd.emit_err   = 1'b1;
          cmd.err_status = err_code;
          phase_next     = PH_DONE;
          state_next     = ST_IDLE;
        end
      end
      ST_END: begin
        state_next = ST_IDLE;
        if (stat.last_in) begin
          phase_next = PH_DONE;
          // data words already sent rule out the empty check
          if (stat.bw_zero && stat.size_nonzero) begin
            err_code_next = STAT_EMPTY;
            state_next    = ST_ERROR;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/lzss_rle_byte_decoder.sv
// lzss decoder with run-length fill tokens, one compressed byte per input word
// input channel: in_valid/in_ready with in_word (in_byte, last_byte); the stream
// opens with a 4-byte little-endian decoded size, then 16-bit tokens and literals
// output channel: out_valid/out_ready with out_word (out_byte, last_of_run, status);
// last_of_run marks the final output word caused by one input word
// sequence: a header or token byte is accepted, decoded, then end-checked;
// a literal or fill adds a run step per output word, a match copy a history ram
// read and then a write per word, so a literal is accepted, decoded, emitted, then end-checked;
// a fill can expand to 63 output words and a match to 31, so input rate follows the
// expansion ratio; one input word is worked on at a time
// a finished word waits in the output register while the next input is taken;
// when out_ready is low the sequencer holds before loading the next word
// reset clears the parser, size and byte counters; the history ram is not cleared,
// entries not yet written read as zero through the write-pointer wrap tracking
// any error word (status nonzero) or a last_byte ends the stream: in_ready stays
// low until the next reset
module lzss_rle_byte_decoder import lrd_pkg::*; #(
  parameter int HISTORY_DEPTH = 128
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  lrd_cmd_t  cmd;
  lrd_stat_t stat;

  lrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat      (stat)
  );

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status != STAT_OK) |-> out_word.last_of_run)
    else $error("error word not marked last");

  a_err_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.status != STAT_OK) |-> (out_word.out_byte == 8'd0))
    else $error("error word carries data");

  a_err_stops_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (out_word.status != STAT_OK) |=> !in_ready)
    else $error("input taken after error");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while decoding");

endmodule
